// ===== src/asw_pkg.sv =====
// shared types, constants and codes of the arq sender window
// no dependencies
package asw_pkg;

  localparam int SLOTS     = 8;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int TIME_BITS = 32;
  localparam int SEQ_W     = 8;
  localparam int KIND_W    = 3;
  localparam int FUNC_W    = 2;
  localparam int ID_W      = 16;
  localparam int WIN_W     = 4;
  localparam int TMO_W     = 20;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [FUNC_W-1:0] FN_SEND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ACK  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAKEN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CORRUPT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RESEND  = 3'd5;

  localparam logic [1:0] REG_OWN_ID  = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [ID_W-1:0]  OWN_ID_RST  = '0;
  localparam logic [WIN_W-1:0] WINDOW_RST  = 4'd8;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 20'd100000;
  localparam logic [SEQ_W-1:0] SEQ_RST     = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
    logic              found;
  } res_t;

  typedef struct packed {
    logic                 alloc;
    logic                 free;
    logic                 renew;
    logic [SLOT_W-1:0]    idx;
    logic [SEQ_W-1:0]     seq;
    logic [TIME_BITS-1:0] deadline;
  } slot_wr_t;

  typedef struct packed {
    logic                 valid;
    logic [SEQ_W-1:0]     seq;
    logic [TIME_BITS-1:0] deadline;
  } slot_rd_t;

endpackage

// ===== src/arq_sender_window.sv =====
// sender window of a selective-repeat arq with SLOTS retransmission slots.
// a send request, an ack or a time tick is taken as one input word while the
// block is idle; the slots are then scanned one per cycle through a single
// compare/subtract unit, and the scan pauses while the output word is not taken.
// in_ready is low from the accepting edge until idle again: via prep, scan and
// flush on a send, a good own ack or a tick, via flush alone on a refused send,
// corrupt or foreign ack, never on an unused code; the final word pauses too.
// a tick emits one resend word per expired slot in slot order; the last word of an
// input with words sets out_last. depends on asw_pkg, asw_slots, asw_scan
module arq_sender_window import asw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ID_W-1:0]     in_ack_dst,
  input  logic [SEQ_W-1:0]    in_ack_seq,
  input  logic                in_ack_crc_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic [SEQ_W-1:0]    out_seq,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_slot_found,
  output logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic [SEQ_W-1:0]     ack_seq_r, ack_seq_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] new_dl_r, new_dl_nxt;
  logic [SEQ_W-1:0]     next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]     last_sent_r, last_sent_nxt;
  logic [SEQ_W-1:0]     last_acked_r, last_acked_nxt;
  logic [ID_W-1:0]      own_id_r;
  logic [WIN_W-1:0]     win_r;
  logic [TMO_W-1:0]     tmo_r;
  logic                 pend_valid_r, pend_valid_nxt;
  res_t                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_r, out_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_fire;
  logic                 out_free;
  logic                 push;
  logic                 push_last;
  logic                 hit;
  logic                 idx_end;
  logic                 win_open;
  logic [SEQ_W-1:0]     in_flight;
  logic                 cfg_wr;
  slot_wr_t             wr;
  slot_rd_t             entry;

  asw_slots u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (idx_r),
    .wr     (wr),
    .rd     (entry)
  );

  asw_scan u_scan (
    .func    (func_r),
    .entry   (entry),
    .ack_seq (ack_seq_r),
    .now     (now_r),
    .hit     (hit)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign idx_end   = (idx_r == SLOT_W'(SLOTS - 1));
  assign in_flight = last_sent_r - last_acked_r;
  assign win_open  = (in_flight < {{(SEQ_W-WIN_W){1'b0}}, win_r});

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    func_nxt       = func_r;
    ack_seq_nxt    = ack_seq_r;
    now_nxt        = now_r;
    new_dl_nxt     = new_dl_r;
    next_seq_nxt   = next_seq_r;
    last_sent_nxt  = last_sent_r;
    last_acked_nxt = last_acked_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    push           = 1'b0;
    push_last      = 1'b0;
    wr             = '0;
    wr.idx         = idx_r;
    wr.seq         = next_seq_r;
    wr.deadline    = new_dl_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt    = in_func;
          ack_seq_nxt = in_ack_seq;
          idx_nxt     = '0;
          case (in_func)
            FN_SEND: begin
              if (win_open) begin
                state_nxt = ST_PREP;
              end else begin
                pend_valid_nxt = 1'b1;
                pend_nxt       = '{KIND_FULL, next_seq_r, '0, 1'b0};
                state_nxt      = ST_FLUSH;
              end
            end
            FN_ACK: begin
              if (!in_ack_crc_ok) begin
                pend_valid_nxt = 1'b1;
                pend_nxt       = '{KIND_CORRUPT, in_ack_seq, '0, 1'b0};
                state_nxt      = ST_FLUSH;
              end else if (in_ack_dst != own_id_r) begin
                pend_valid_nxt = 1'b1;
                pend_nxt       = '{KIND_IGNORED, in_ack_seq, '0, 1'b0};
                state_nxt      = ST_FLUSH;
              end else begin
                state_nxt = ST_PREP;
              end
            end
            FN_TICK: begin
              now_nxt   = now_r + TIME_BITS'(1);
              state_nxt = ST_PREP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_PREP: begin
        new_dl_nxt = now_r + {{(TIME_BITS-TMO_W){1'b0}}, tmo_r};
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) begin
          if (!pend_valid_r || out_free) begin
            push           = pend_valid_r;
            pend_valid_nxt = 1'b1;
            case (func_r)
              FN_SEND: begin
                wr.alloc      = 1'b1;
                pend_nxt      = '{KIND_SENT, next_seq_r, idx_r, 1'b1};
                next_seq_nxt  = next_seq_r + SEQ_W'(1);
                last_sent_nxt = last_sent_r + SEQ_W'(1);
                state_nxt     = ST_FLUSH;
              end
              FN_ACK: begin
                wr.free        = 1'b1;
                pend_nxt       = '{KIND_TAKEN, ack_seq_r, idx_r, 1'b0};
                last_acked_nxt = last_acked_r + SEQ_W'(1);
                state_nxt      = ST_FLUSH;
              end
              default: begin
                wr.renew = 1'b1;
                pend_nxt = '{KIND_RESEND, entry.seq, idx_r, 1'b0};
                idx_nxt  = idx_r + SLOT_W'(1);
                if (idx_end) state_nxt = ST_FLUSH;
              end
            endcase
          end
        end else if (idx_end) begin
          state_nxt = ST_FLUSH;
          case (func_r)
            FN_SEND: begin
              pend_valid_nxt = 1'b1;
              pend_nxt       = '{KIND_SENT, next_seq_r, '0, 1'b0};
              next_seq_nxt   = next_seq_r + SEQ_W'(1);
              last_sent_nxt  = last_sent_r + SEQ_W'(1);
            end
            FN_ACK: begin
              pend_valid_nxt = 1'b1;
              pend_nxt       = '{KIND_IGNORED, ack_seq_r, '0, 1'b0};
            end
            default: begin
              pend_valid_nxt = pend_valid_r;
            end
          endcase
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          push_last      = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
      out_last_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      now_r        <= '0;
      next_seq_r   <= '0;
      last_sent_r  <= SEQ_RST;
      last_acked_r <= SEQ_RST;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      next_seq_r   <= next_seq_nxt;
      last_sent_r  <= last_sent_nxt;
      last_acked_r <= last_acked_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    func_r    <= func_nxt;
    ack_seq_r <= ack_seq_nxt;
    new_dl_r  <= new_dl_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= OWN_ID_RST;
      win_r    <= WINDOW_RST;
      tmo_r    <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_OWN_ID:  own_id_r <= pwdata[ID_W-1:0];
        REG_WINDOW:  win_r    <= pwdata[WIN_W-1:0];
        REG_TIMEOUT: tmo_r    <= pwdata[TMO_W-1:0];
        default: begin
          own_id_r <= own_id_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_OWN_ID:  prdata = {{(DATA_W-ID_W){1'b0}}, own_id_r};
      REG_WINDOW:  prdata = {{(DATA_W-WIN_W){1'b0}}, win_r};
      REG_TIMEOUT: prdata = {{(DATA_W-TMO_W){1'b0}}, tmo_r};
      default:     prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_seq        = out_r.seq;
  assign out_slot       = out_r.slot;
  assign out_slot_found = out_r.found;
  assign out_last       = out_last_r;

endmodule

// ===== src/asw_slots.sv =====
// retransmission slot table: valid bits, sequence numbers, deadlines
// depends on asw_pkg
module asw_slots import asw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] rd_idx,
  input  slot_wr_t          wr,
  output slot_rd_t          rd
);

  logic [SLOTS-1:0]     valid_r;
  logic [SLOTS-1:0]     valid_nxt;
  logic [SEQ_W-1:0]     seq_r [SLOTS];
  logic [TIME_BITS-1:0] dl_r  [SLOTS];

  always_comb begin
    valid_nxt = valid_r;
    if (wr.alloc) valid_nxt[wr.idx] = 1'b1;
    if (wr.free)  valid_nxt[wr.idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.alloc) begin
      seq_r[wr.idx] <= wr.seq;
    end
    if (wr.alloc || wr.renew) begin
      dl_r[wr.idx] <= wr.deadline;
    end
  end

  assign rd.valid    = valid_r[rd_idx];
  assign rd.seq      = seq_r[rd_idx];
  assign rd.deadline = dl_r[rd_idx];

endmodule

// ===== src/asw_scan.sv =====
// per-slot test of the scan: free slot, ack match or expired deadline
// depends on asw_pkg
module asw_scan import asw_pkg::*; (
  input  logic [FUNC_W-1:0]    func,
  input  slot_rd_t             entry,
  input  logic [SEQ_W-1:0]     ack_seq,
  input  logic [TIME_BITS-1:0] now,
  output logic                 hit
);

  logic [TIME_BITS-1:0] diff;

  assign diff = now - entry.deadline;

  always_comb begin
    case (func)
      FN_SEND: hit = !entry.valid;
      FN_ACK:  hit = entry.valid && (entry.seq == ack_seq);
      FN_TICK: hit = entry.valid && !diff[TIME_BITS-1];
      default: hit = 1'b0;
    endcase
  end

endmodule

// ===== sim/asw_checker.sv =====
`timescale 1ns / 1ps
// result checker for the arq sender window: follows config writes and both channels,
// keeps its own copy of the slot window and compares every output word in order
// depends on asw_pkg
module asw_checker import asw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ID_W-1:0]   in_ack_dst,
  input  logic [SEQ_W-1:0]  in_ack_seq,
  input  logic              in_ack_crc_ok,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KIND_W-1:0] out_kind,
  input  logic [SEQ_W-1:0]  out_seq,
  input  logic [SLOT_W-1:0] out_slot,
  input  logic              out_slot_found,
  input  logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                owed_count,
  output int                fail_count
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
    logic              found;
    logic              last;
  } word_t;

  word_t                owed_words[$];
  word_t                held;
  word_t                want;
  logic                 have_held;

  logic [SLOTS-1:0]     live;
  logic [SEQ_W-1:0]     slot_seq [SLOTS];
  logic [TIME_BITS-1:0] slot_due [SLOTS];
  logic [TIME_BITS-1:0] now_ticks;
  logic [SEQ_W-1:0]     seq_next;
  logic [SEQ_W-1:0]     sent_mark;
  logic [SEQ_W-1:0]     acked_mark;
  logic [ID_W-1:0]      my_id;
  logic [WIN_W-1:0]     win_size;
  logic [TMO_W-1:0]     tmo_ticks;

  // one word is held back so the final word of an input gets its last flag
  task automatic emit(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                      input int slot, input logic found);
    if (have_held) owed_words.push_back(held);
    held.kind  = kind;
    held.seq   = seq;
    held.slot  = SLOT_W'(slot);
    held.found = found;
    held.last  = 1'b0;
    have_held  = 1'b1;
  endtask

  task automatic window_step(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] dst,
                             input logic [SEQ_W-1:0] aseq, input logic crc_ok);
    int                   pick;
    logic [SEQ_W-1:0]     span;
    logic [TIME_BITS-1:0] age;
    pick = -1;
    span = sent_mark - acked_mark;
    have_held = 1'b0;
    case (fn)
      FN_SEND: begin
        if (span < SEQ_W'(win_size)) begin
          for (int i = SLOTS - 1; i >= 0; i--) if (!live[i]) pick = i;
          if (pick >= 0) begin
            live[pick]     = 1'b1;
            slot_seq[pick] = seq_next;
            slot_due[pick] = now_ticks + TIME_BITS'(tmo_ticks);
            emit(KIND_SENT, seq_next, pick, 1'b1);
          end else begin
            emit(KIND_SENT, seq_next, 0, 1'b0);
          end
          seq_next  = seq_next + 1'b1;
          sent_mark = sent_mark + 1'b1;
        end else begin
          emit(KIND_FULL, seq_next, 0, 1'b0);
        end
      end
      FN_ACK: begin
        if (!crc_ok) begin
          emit(KIND_CORRUPT, aseq, 0, 1'b0);
        end else if (dst != my_id) begin
          emit(KIND_IGNORED, aseq, 0, 1'b0);
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--) if (live[i] && slot_seq[i] == aseq) pick = i;
          if (pick >= 0) begin
            live[pick] = 1'b0;
            acked_mark = acked_mark + 1'b1;
            emit(KIND_TAKEN, aseq, pick, 1'b0);
          end else begin
            emit(KIND_IGNORED, aseq, 0, 1'b0);
          end
        end
      end
      FN_TICK: begin
        now_ticks = now_ticks + 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          age = now_ticks - slot_due[i];
          if (live[i] && !age[TIME_BITS-1]) begin
            slot_due[i] = now_ticks + TIME_BITS'(tmo_ticks);
            emit(KIND_RESEND, slot_seq[i], i, 1'b0);
          end
        end
      end
      default: ;
    endcase
    if (have_held) begin
      held.last = 1'b1;
      owed_words.push_back(held);
      have_held = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_words.delete();
      have_held  = 1'b0;
      live       = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_seq[i] = SEQ_RST;
        slot_due[i] = '0;
      end
      now_ticks  = '0;
      seq_next   = '0;
      sent_mark  = SEQ_RST;
      acked_mark = SEQ_RST;
      my_id      = OWN_ID_RST;
      win_size   = WINDOW_RST;
      tmo_ticks  = TIMEOUT_RST;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_OWN_ID:  my_id     = pwdata[ID_W-1:0];
          REG_WINDOW:  win_size  = pwdata[WIN_W-1:0];
          REG_TIMEOUT: tmo_ticks = pwdata[TMO_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_words.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: kind %0d seq %0d slot %0d found %0b last %0b",
                     out_kind, out_seq, out_slot, out_slot_found, out_last);
          fail_count++;
        end else begin
          want = owed_words.pop_front();
          if (want.kind !== out_kind || want.seq !== out_seq || want.slot !== out_slot ||
              want.found !== out_slot_found || want.last !== out_last) begin
            if (fail_count < 10)
              $display("mismatch: expected kind %0d seq %0d slot %0d found %0b last %0b, %s",
                       want.kind, want.seq, want.slot, want.found, want.last,
                       $sformatf("got kind %0d seq %0d slot %0d found %0b last %0b",
                                 out_kind, out_seq, out_slot, out_slot_found, out_last));
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) window_step(in_func, in_ack_dst, in_ack_seq, in_ack_crc_ok);
    end
    owed_count <= owed_words.size();
  end

endmodule

// ===== sim/arq_sender_window_tb.sv =====
`timescale 1ns / 1ps
// testbench top for arq_sender_window: clock, reset, config writes, input words
// and a stalling receiver; the verdict comes from the asw_checker failure count
// depends on asw_pkg, arq_sender_window, asw_checker
module arq_sender_window_tb;
  import asw_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam int SETTLE      = SLOTS + 12;
  localparam int LONG_HOLD   = 60;
  localparam int QUIET_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func;
  logic [ID_W-1:0]   in_ack_dst;
  logic [SEQ_W-1:0]  in_ack_seq;
  logic              in_ack_crc_ok;
  logic              out_valid;
  logic              out_ready;
  logic [KIND_W-1:0] out_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [SLOT_W-1:0] out_slot;
  logic              out_slot_found;
  logic              out_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int                owed_count;
  int                fail_count;

  logic [SEQ_W-1:0]  live_seqs[$];
  logic [SEQ_W-1:0]  freed_seq = '0;
  logic [ID_W-1:0]   cur_id    = OWN_ID_RST;
  logic              calm      = 1'b0;
  logic              hold_long = 1'b0;

  always #6 clk = ~clk;

  arq_sender_window u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_ack_dst(in_ack_dst), .in_ack_seq(in_ack_seq), .in_ack_crc_ok(in_ack_crc_ok),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind), .out_seq(out_seq),
    .out_slot(out_slot), .out_slot_found(out_slot_found), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  asw_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_ack_dst(in_ack_dst), .in_ack_seq(in_ack_seq), .in_ack_crc_ok(in_ack_crc_ok),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind), .out_seq(out_seq),
    .out_slot(out_slot), .out_slot_found(out_slot_found), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .owed_count(owed_count), .fail_count(fail_count)
  );

  // sequence numbers currently held in slots, used to aim acks
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_kind == KIND_SENT && out_slot_found) begin
        live_seqs.push_back(out_seq);
      end else if (out_kind == KIND_TAKEN) begin
        freed_seq = out_seq;
        for (int i = 0; i < live_seqs.size(); i++) begin
          if (live_seqs[i] == out_seq) begin
            live_seqs.delete(i);
            break;
          end
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic offer_word(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] dst,
                            input logic [SEQ_W-1:0] aseq, input logic crc_ok);
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_ack_dst    <= dst;
    in_ack_seq    <= aseq;
    in_ack_crc_ok <= crc_ok;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic maybe_gap(input logic gaps_ok);
    if (gaps_ok && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_owed();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_owed();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [ID_W-1:0] id, input logic [WIN_W-1:0] win,
                           input logic [TMO_W-1:0] tmo);
    settle();
    reg_write(REG_OWN_ID, DATA_W'(id));
    reg_write(REG_WINDOW, DATA_W'(win));
    reg_write(REG_TIMEOUT, DATA_W'(tmo));
    cur_id = id;
  endtask

  task automatic ack_all_live();
    for (int k = 0; k < 4 * SLOTS && live_seqs.size() != 0; k++) begin
      offer_word(FN_ACK, cur_id, live_seqs[0], 1'b1);
      wait_owed();
    end
  endtask

  task automatic random_run(input int count, input logic gaps_ok);
    int roll;
    int pick;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (roll < 34) begin
        offer_word(FN_SEND, ID_W'($urandom), SEQ_W'($urandom), 1'($urandom));
      end else if (roll < 70) begin
        if (live_seqs.size() != 0 && pick < 7)
          offer_word(FN_ACK, cur_id, live_seqs[$urandom_range(0, live_seqs.size() - 1)], 1'b1);
        else if (pick < 8)
          offer_word(FN_ACK, cur_id, freed_seq, 1'b1);
        else
          offer_word(FN_ACK, (pick == 8) ? cur_id : ID_W'($urandom), SEQ_W'($urandom),
                     1'($urandom));
      end else if (roll < 96) begin
        offer_word(FN_TICK, ID_W'($urandom), SEQ_W'($urandom), 1'($urandom));
      end else begin
        offer_word(FN_SPARE, ID_W'($urandom), SEQ_W'($urandom), 1'($urandom));
      end
      maybe_gap(gaps_ok);
    end
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= FN_SEND;
    in_ack_dst    <= '0;
    in_ack_seq    <= '0;
    in_ack_crc_ok <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unmatched, corrupt, unused code, empty tick, send, foreign ack, matching ack
    offer_word(FN_ACK, 16'h0000, 8'h00, 1'b1);
    offer_word(FN_ACK, 16'hFFFF, 8'hFF, 1'b0);
    offer_word(FN_SPARE, 16'hFFFF, 8'hFF, 1'b1);
    offer_word(FN_TICK, 16'h0000, 8'h00, 1'b0);
    offer_word(FN_SEND, 16'h0000, 8'h00, 1'b0);
    offer_word(FN_ACK, 16'h0001, 8'h00, 1'b1);
    offer_word(FN_ACK, 16'h0000, 8'h00, 1'b1);

    // fill every slot, overrun the window, duplicate ack, full resend bursts
    configure(16'hFFFF, 4'd8, 20'd1);
    repeat (9) offer_word(FN_SEND, 16'h5A5A, 8'hA5, 1'b1);
    offer_word(FN_ACK, 16'hFFFF, 8'd4, 1'b1);
    offer_word(FN_ACK, 16'hFFFF, 8'd4, 1'b1);
    offer_word(FN_SEND, 16'h0000, 8'h00, 1'b0);
    offer_word(FN_TICK, 16'h0000, 8'h00, 1'b0);
    offer_word(FN_TICK, 16'h0000, 8'h00, 1'b0);

    // hold one slot while later sends come and go through the others
    configure(16'h8001, 4'd15, 20'hFFFFF);
    ack_all_live();
    offer_word(FN_SEND, 16'h0000, 8'h00, 1'b0);
    wait_owed();
    repeat (12) begin
      offer_word(FN_SEND, 16'h0000, 8'h00, 1'b0);
      wait_owed();
      offer_word(FN_ACK, cur_id, live_seqs[live_seqs.size() - 1], 1'b1);
      wait_owed();
    end
    ack_all_live();

    configure(ID_W'($urandom), 4'd1, 20'd3);
    random_run(40, 1'b1);

    configure(16'h0000, 4'd0, 20'd7);
    random_run(15, 1'b1);

    configure(ID_W'($urandom), 4'd8, TMO_W'($urandom_range(2, 30)));
    random_run(25, 1'b1);
    hold_long = 1'b1;
    random_run(12, 1'b0);
    wait_owed();
    random_run(25, 1'b1);

    // sends with every slot taken
    configure(ID_W'($urandom), 4'd15, 20'hFFFFF);
    ack_all_live();
    repeat (10) offer_word(FN_SEND, ID_W'($urandom), SEQ_W'($urandom), 1'($urandom));
    wait_owed();
    ack_all_live();

    configure(ID_W'($urandom), WIN_W'($urandom_range(4, 8)), TMO_W'($urandom_range(1, 20)));
    calm = 1'b1;
    random_run(70, 1'b1);

    settle();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
